>>> hw/rtl/pip_pkg.sv
// Shared widths and codes for the point-in-polygon test block.
package pip_pkg;

    localparam int FUNC_W = 2;
    localparam int LOC_W  = 2;
    localparam int HELD_W = 7;
    localparam int TOL_W  = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_QUERY  = 2'd2
    } t_func;

    typedef enum logic [LOC_W-1:0] {
        LOC_OUTSIDE  = 2'd0,
        LOC_INSIDE   = 2'd1,
        LOC_BOUNDARY = 2'd2
    } t_loc;

endpackage

>>> hw/rtl/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/point_in_polygon_test.sv
// Point-in-polygon test by even-odd ray casting over a stored vertex list.
//
// Input channel (i_in_valid / o_in_ready) carries one word: i_func with
// i_coord_x and i_coord_y. Clear empties the vertex list, append stores one
// vertex (dropped and flagged once MAX_VERTICES are held), query locates the
// point. Only a query gives a result word on the output channel
// (o_out_valid / i_out_ready): o_location, o_vertices_held, o_overflowed.
// Clear and append are done in S_IDLE. A query with n >= 3 vertices walks
// the vertex RAM one entry per cycle, n + 1 reads (vertex 0 is read again to
// close the polygon), then three pipeline stages (differences, products,
// compare); S_FIN then loads the output register and raises o_out_valid.
// A query with fewer than three vertices goes straight to S_FIN and answers
// outside. One word is worked on at a time; the RAM read port sets the
// pace. A result waiting in the output register does not block clear or
// append; a later query holds in its final state until the register frees.
// i_rst_n (synchronous, active low) empties the list, clears the overflow
// flag and the tolerance; RAM contents are not cleared and need no pass.
// The tolerance register is written by i_cfg_we / i_cfg_wdata; the user must write it only while idle (not enforced).
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pip_pkg::TOL_W-1:0]          i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [pip_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [COORD_BITS-1:0]       i_coord_x,
    input  logic signed [COORD_BITS-1:0]       i_coord_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [pip_pkg::LOC_W-1:0]          o_location,
    output logic [pip_pkg::HELD_W-1:0]         o_vertices_held,
    output logic                               o_overflowed
);

    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int RW = 2 * COORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state                  r_state, n_state;
    logic [TOL_W-1:0]        r_tol, n_tol;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_ovf, n_ovf;
    logic signed [COORD_BITS-1:0] r_px, n_px, r_py, n_py;
    logic [CW-1:0]           r_n, n_n;
    logic [HELD_W-1:0]       r_q_held, n_q_held;
    logic                    r_q_ovf, n_q_ovf;
    logic [CW-1:0]           r_k, n_k;
    logic                    r_bound, n_bound;
    logic                    r_inside, n_inside;
    logic [LOC_W-1:0]        r_loc, n_loc;
    logic                    r_out_valid, n_out_valid;
    logic [LOC_W-1:0]        r_location, n_location;
    logic [HELD_W-1:0]       r_held, n_held;
    logic                    r_ovfl, n_ovfl;

    logic                    in_acc;
    logic                    ram_we;
    logic [AW-1:0]           rd_addr;
    logic [RW-1:0]           rd_data;
    logic [CW+HELD_W-1:0]    cnt_ext;

    // read pipeline
    logic                    r_rd_v, r_rd_first, r_rd_last;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic signed [COORD_BITS-1:0] qx, qy;

    // difference stage
    logic                    r_e1_v, r_e1_last, r_e1_box, r_e1_xc, r_e1_dpos;
    logic signed [DW-1:0]    r_e1_dxp, r_e1_dyp, r_e1_ex, r_e1_ey;
    logic signed [DW-1:0]    dxp, dyp, ex, ey;
    logic                    box, xc, dpos;

    // product stage
    logic                    r_e2_v, r_e2_last, r_e2_box, r_e2_xc, r_e2_dpos;
    logic signed [PW-1:0]    r_e2_lhs, r_e2_rhs;

    // compare stage
    logic signed [XW-1:0]    cross_v, tol_s;
    logic                    on_edge, left, bound_n, inside_n;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign ram_we     = in_acc && (i_func == FUNC_APPEND) && (r_cnt < CW'(MAX_VERTICES));
    assign rd_addr    = (r_k == r_n) ? '0 : r_k[AW-1:0];
    assign cnt_ext    = {{HELD_W{1'b0}}, r_cnt};

    pip_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata({i_coord_x, i_coord_y}),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    assign qx = $signed(rd_data[RW-1:COORD_BITS]);
    assign qy = $signed(rd_data[COORD_BITS-1:0]);

    always_comb begin
        dxp  = {r_px[COORD_BITS-1], r_px} - {r_cx[COORD_BITS-1], r_cx};
        dyp  = {r_py[COORD_BITS-1], r_py} - {r_cy[COORD_BITS-1], r_cy};
        ex   = {qx[COORD_BITS-1], qx} - {r_cx[COORD_BITS-1], r_cx};
        ey   = {qy[COORD_BITS-1], qy} - {r_cy[COORD_BITS-1], r_cy};
        box  = ((r_px >= r_cx && r_px <= qx) || (r_px >= qx && r_px <= r_cx))
            && ((r_py >= r_cy && r_py <= qy) || (r_py >= qy && r_py <= r_cy));
        xc   = (r_cy > r_py) != (qy > r_py);
        dpos = qy > r_cy;
    end

    always_comb begin
        cross_v  = {r_e2_rhs[PW-1], r_e2_rhs} - {r_e2_lhs[PW-1], r_e2_lhs};
        tol_s    = $signed({{(XW-TOL_W){1'b0}}, r_tol});
        on_edge  = r_e2_box && (cross_v <= tol_s) && (cross_v >= -tol_s);
        left     = r_e2_dpos ? (cross_v > 0) : (cross_v < 0);
        bound_n  = r_bound || on_edge;
        inside_n = r_inside ^ (r_e2_xc && left);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_WALK);
            r_e1_v <= r_rd_v && !r_rd_first;
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_k == '0);
        r_rd_last  <= (r_k == r_n);
        if (r_rd_v) begin
            r_cx <= qx;
            r_cy <= qy;
        end
        r_e1_last <= r_rd_last;
        r_e1_dxp  <= dxp;
        r_e1_dyp  <= dyp;
        r_e1_ex   <= ex;
        r_e1_ey   <= ey;
        r_e1_box  <= box;
        r_e1_xc   <= xc;
        r_e1_dpos <= dpos;
        r_e2_last <= r_e1_last;
        r_e2_lhs  <= r_e1_dxp * r_e1_ey;
        r_e2_rhs  <= r_e1_dyp * r_e1_ex;
        r_e2_box  <= r_e1_box;
        r_e2_xc   <= r_e1_xc;
        r_e2_dpos <= r_e1_dpos;
    end

    always_comb begin
        n_state     = r_state;
        n_tol       = r_tol;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_px        = r_px;
        n_py        = r_py;
        n_n         = r_n;
        n_q_held    = r_q_held;
        n_q_ovf     = r_q_ovf;
        n_k         = r_k;
        n_bound     = r_bound;
        n_inside    = r_inside;
        n_loc       = r_loc;
        n_out_valid = r_out_valid;
        n_location  = r_location;
        n_held      = r_held;
        n_ovfl      = r_ovfl;

        if (i_cfg_we) begin
            n_tol = i_cfg_wdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_e2_v) begin
            n_bound  = bound_n;
            n_inside = inside_n;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_func)
                        FUNC_CLEAR: begin
                            n_cnt = '0;
                            n_ovf = 1'b0;
                        end
                        FUNC_APPEND: begin
                            if (r_cnt < CW'(MAX_VERTICES)) begin
                                n_cnt = r_cnt + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_QUERY: begin
                            n_px     = i_coord_x;
                            n_py     = i_coord_y;
                            n_n      = r_cnt;
                            n_q_held = cnt_ext[HELD_W-1:0];
                            n_q_ovf  = r_ovf;
                            n_k      = '0;
                            n_bound  = 1'b0;
                            n_inside = 1'b0;
                            if (r_cnt < CW'(3)) begin
                                n_loc   = LOC_OUTSIDE;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                n_k = r_k + CW'(1);
                if (r_k == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_e2_v && r_e2_last) begin
                    n_loc   = bound_n ? LOC_BOUNDARY : (inside_n ? LOC_INSIDE : LOC_OUTSIDE);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_location  = r_loc;
                    n_held      = r_q_held;
                    n_ovfl      = r_q_ovf;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
            r_n         <= '0;
            r_q_held    <= '0;
            r_q_ovf     <= 1'b0;
            r_k         <= '0;
            r_bound     <= 1'b0;
            r_inside    <= 1'b0;
            r_loc       <= LOC_OUTSIDE;
            r_out_valid <= 1'b0;
            r_location  <= LOC_OUTSIDE;
            r_held      <= '0;
            r_ovfl      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tol       <= n_tol;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_px        <= n_px;
            r_py        <= n_py;
            r_n         <= n_n;
            r_q_held    <= n_q_held;
            r_q_ovf     <= n_q_ovf;
            r_k         <= n_k;
            r_bound     <= n_bound;
            r_inside    <= n_inside;
            r_loc       <= n_loc;
            r_out_valid <= n_out_valid;
            r_location  <= n_location;
            r_held      <= n_held;
            r_ovfl      <= n_ovfl;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_location      = r_location;
    assign o_vertices_held = r_held;
    assign o_overflowed    = r_ovfl;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE) && !r_rd_v && !r_e1_v && !r_e2_v)
        else $error("vertex write while a walk is in flight");

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e2_v && r_e2_last) |-> (r_state == S_DRAIN))
        else $error("closing edge outside drain");

    a_walk_reads_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_k <= r_n) && (r_n >= CW'(3)))
        else $error("walk index out of range");

    a_loc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_location == LOC_OUTSIDE || o_location == LOC_INSIDE
                         || o_location == LOC_BOUNDARY))
        else $error("bad location code");

endmodule

>>> verif/polygon_location_checker.sv
// Checker for the point-in-polygon block: predicts each query result and compares it.
module polygon_location_checker #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pip_pkg::TOL_W-1:0]    i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [pip_pkg::FUNC_W-1:0]   i_func,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [pip_pkg::LOC_W-1:0]    i_location,
    input  logic [pip_pkg::HELD_W-1:0]   i_vertices_held,
    input  logic                         i_overflowed,
    output int                           o_mismatch_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pip_pkg::*;

    typedef struct packed {
        t_loc              loc;
        logic [HELD_W-1:0] held;
        logic              ovf;
    } t_location_word;

    longint         corner_x [MAX_VERTICES];
    longint         corner_y [MAX_VERTICES];
    int             corner_count  = 0;
    logic           overflow_seen = 1'b0;
    int             tolerance     = 0;
    t_location_word expected_words [$];
    int             mismatches    = 0;
    int             pending_total = 0;

    assign o_mismatch_count = mismatches;
    assign o_pending        = pending_total;

    function automatic bit lies_on_edge(longint px, longint py, longint sx, longint sy,
                                        longint ex, longint ey);
        longint cross_prod;
        longint mag;
        cross_prod = (py - sy) * (ex - sx) - (px - sx) * (ey - sy);
        mag        = (cross_prod < 0) ? -cross_prod : cross_prod;
        if (mag > longint'(tolerance))
            return 1'b0;
        return px >= ((sx < ex) ? sx : ex) && px <= ((sx < ex) ? ex : sx) &&
               py >= ((sy < ey) ? sy : ey) && py <= ((sy < ey) ? ey : sy);
    endfunction

    function automatic t_loc locate_point(longint px, longint py);
        bit     inside_flag;
        bit     left;
        int     j;
        longint cx, cy, nx, ny, d, lhs, rhs;
        inside_flag = 1'b0;
        if (corner_count < 3)
            return LOC_OUTSIDE;
        for (int i = 0; i < corner_count; i++) begin
            j  = (i + 1 == corner_count) ? 0 : i + 1;
            cx = corner_x[i];
            cy = corner_y[i];
            nx = corner_x[j];
            ny = corner_y[j];
            if (lies_on_edge(px, py, cx, cy, nx, ny))
                return LOC_BOUNDARY;
            if ((cy > py) != (ny > py)) begin
                d    = ny - cy;
                lhs  = (px - cx) * d;
                rhs  = (py - cy) * (nx - cx);
                left = (d > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left)
                    inside_flag = !inside_flag;
            end
        end
        return inside_flag ? LOC_INSIDE : LOC_OUTSIDE;
    endfunction

    always @(posedge i_clk) begin
        t_location_word want;
        if (!i_rst_n) begin
            corner_count  = 0;
            overflow_seen = 1'b0;
            tolerance     = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we)
                tolerance = int'(i_cfg_wdata);
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: location %0d held %0d overflowed %0b",
                             $time, i_location, i_vertices_held, i_overflowed);
                end else begin
                    want = expected_words.pop_front();
                    if (i_location !== want.loc) begin
                        mismatches++;
                        $display("%0t: location expected %0d, actual %0d",
                                 $time, want.loc, i_location);
                    end
                    if (i_vertices_held !== want.held) begin
                        mismatches++;
                        $display("%0t: vertices_held expected %0d, actual %0d",
                                 $time, want.held, i_vertices_held);
                    end
                    if (i_overflowed !== want.ovf) begin
                        mismatches++;
                        $display("%0t: overflowed expected %0b, actual %0b",
                                 $time, want.ovf, i_overflowed);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_func)
                    FUNC_CLEAR: begin
                        corner_count  = 0;
                        overflow_seen = 1'b0;
                    end
                    FUNC_APPEND: begin
                        if (corner_count < MAX_VERTICES) begin
                            corner_x[corner_count] = longint'(i_coord_x);
                            corner_y[corner_count] = longint'(i_coord_y);
                            corner_count++;
                        end else begin
                            overflow_seen = 1'b1;
                        end
                    end
                    FUNC_QUERY: begin
                        want.loc  = locate_point(longint'(i_coord_x), longint'(i_coord_y));
                        want.held = HELD_W'(corner_count);
                        want.ovf  = overflow_seen;
                        expected_words = {expected_words, want};
                    end
                    default: ;
                endcase
            end
        end
        pending_total = expected_words.size();
    end

endmodule

>>> verif/point_in_polygon_test_tb.sv
// Testbench top for the point-in-polygon block: stimulus, flow control and verdict.
module point_in_polygon_test_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pip_pkg::*;

    localparam int              MAX_VERTICES  = 64;
    localparam int              COORD_BITS    = 24;
    localparam int              CLK_HALF      = 5;
    localparam int              RESET_CYCLES  = 7;
    localparam int              IDLE_PCT      = 17;
    localparam int              SETTLE_CYCLES = 80;
    localparam int              HOLD_CYCLES   = 300;
    localparam int              STALL_LIMIT   = 4000;
    localparam int              RANDOM_WORDS  = 850;
    localparam int              COORD_MIN     = -(1 << (COORD_BITS - 1));
    localparam int              COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [TOL_W-1:0]             cfg_wdata;
    logic                         in_valid;
    logic                         in_ready;
    logic [FUNC_W-1:0]            func;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         out_valid;
    logic                         out_ready;
    logic [LOC_W-1:0]             location;
    logic [HELD_W-1:0]            vertices_held;
    logic                         overflowed;
    int                           mismatch_count;
    int                           pending_count;

    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int words_sent    = 0;
    int poly_x [$];
    int poly_y [$];

    always #(CLK_HALF) clk = ~clk;

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (func),
        .i_coord_x      (coord_x),
        .i_coord_y      (coord_y),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_location     (location),
        .o_vertices_held(vertices_held),
        .o_overflowed   (overflowed)
    );

    polygon_location_checker #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_func          (func),
        .i_coord_x       (coord_x),
        .i_coord_y       (coord_y),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_location      (location),
        .i_vertices_held (vertices_held),
        .i_overflowed    (overflowed),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending_count)
    );

    function automatic int pick_coord(int span);
        if (span == 0)
            return int'($urandom()) >>> (32 - COORD_BITS);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic send_word(logic [FUNC_W-1:0] f, int x, int y);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= f;
        coord_x  <= COORD_BITS'(x);
        coord_y  <= COORD_BITS'(y);
        do @(posedge clk); while (!(in_valid && in_ready));
        if (f == FUNC_CLEAR) begin
            poly_x.delete();
            poly_y.delete();
        end else if (f == FUNC_APPEND && poly_x.size() < MAX_VERTICES) begin
            poly_x = {poly_x, x};
            poly_y = {poly_y, y};
        end
        if (f != FUNC_UNUSED)
            words_sent++;
    endtask

    task automatic settle_and_set_tolerance(logic [TOL_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left   = 0;
        out_ready   = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int               episode;
        int               tol_step;
        int               first_random;
        int               n_corners;
        int               n_queries;
        int               span;
        int               r;
        int               idx;
        int               nxt;
        int               qx;
        int               qy;
        logic [TOL_W-1:0] tol_value;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        func      = FUNC_CLEAR;
        coord_x   = '0;
        coord_y   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settle_and_set_tolerance('0);

        send_word(FUNC_QUERY, 0, 0);
        send_word(FUNC_APPEND, COORD_MIN, COORD_MIN);
        send_word(FUNC_QUERY, COORD_MIN, COORD_MIN);
        send_word(FUNC_APPEND, COORD_MAX, COORD_MIN);
        send_word(FUNC_QUERY, 0, COORD_MIN);
        send_word(FUNC_APPEND, 0, COORD_MAX);
        send_word(FUNC_QUERY, 0, 0);
        send_word(FUNC_QUERY, COORD_MIN, COORD_MAX);
        send_word(FUNC_QUERY, COORD_MAX, COORD_MIN);
        send_word(FUNC_QUERY, 0, COORD_MIN);
        send_word(FUNC_UNUSED, COORD_MAX, -1);
        send_word(FUNC_QUERY, COORD_MAX, COORD_MAX);
        send_word(FUNC_CLEAR, 0, 0);
        send_word(FUNC_APPEND, 0, 0);
        send_word(FUNC_APPEND, 10, 0);
        send_word(FUNC_APPEND, 10, 10);
        send_word(FUNC_APPEND, 0, 10);
        send_word(FUNC_QUERY, 5, 5);
        send_word(FUNC_QUERY, 10, 5);
        send_word(FUNC_QUERY, 11, 5);
        send_word(FUNC_QUERY, 5, -1);
        send_word(FUNC_QUERY, 0, 10);

        first_random = words_sent;
        episode      = 0;
        tol_step     = 0;
        while (words_sent - first_random < RANDOM_WORDS) begin
            idle_on = !(episode >= 30 && episode < 45);
            if (episode % 8 == 7) begin
                case (tol_step % 5)
                    0:       tol_value = '1;
                    1:       tol_value = TOL_W'(1);
                    2:       tol_value = TOL_W'($urandom_range(2, 64));
                    3:       tol_value = TOL_W'($urandom_range(65535));
                    default: tol_value = '0;
                endcase
                tol_step++;
                settle_and_set_tolerance(tol_value);
            end
            if (episode == 0 || $urandom_range(9) != 0)
                send_word(FUNC_CLEAR, pick_coord(0), pick_coord(0));
            r = $urandom_range(99);
            if (r < 8)
                n_corners = $urandom_range(2);
            else if (r < 93)
                n_corners = $urandom_range(3, 10);
            else
                n_corners = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 6);
            case ($urandom_range(3))
                0:       span = 0;
                1:       span = 8;
                2:       span = 60;
                default: span = 2000;
            endcase
            for (int k = 0; k < n_corners; k++) begin
                if ($urandom_range(32) == 0)
                    send_word(FUNC_UNUSED, pick_coord(0), pick_coord(0));
                send_word(FUNC_APPEND, pick_coord(span), pick_coord(span));
            end
            if (episode == 12 || episode == 60) begin
                hold_requests++;
                n_queries = 8;
            end else begin
                n_queries = $urandom_range(1, 6);
            end
            for (int k = 0; k < n_queries; k++) begin
                r = $urandom_range(9);
                if (poly_x.size() == 0 && (r < 4 || r == 9))
                    r = 4;
                idx = (poly_x.size() > 0) ? $urandom_range(poly_x.size() - 1) : 0;
                nxt = (idx + 1 >= poly_x.size()) ? 0 : idx + 1;
                case (r)
                    0, 1: begin
                        qx = poly_x[idx];
                        qy = poly_y[idx];
                    end
                    2, 3: begin
                        qx = (poly_x[idx] + poly_x[nxt]) >>> 1;
                        qy = (poly_y[idx] + poly_y[nxt]) >>> 1;
                    end
                    4, 5, 6: begin
                        qx = pick_coord(span);
                        qy = pick_coord(span);
                    end
                    7: begin
                        qx = pick_coord(0);
                        qy = pick_coord(0);
                    end
                    8: begin
                        qx = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                        qy = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                    end
                    default: begin
                        qx = poly_x[idx] + int'($urandom_range(2)) - 1;
                        qy = poly_y[idx] + int'($urandom_range(2)) - 1;
                    end
                endcase
                send_word(FUNC_QUERY, qx, qy);
                if ($urandom_range(19) == 0)
                    send_word(FUNC_UNUSED, pick_coord(0), pick_coord(0));
                if ($urandom_range(19) == 0)
                    send_word(FUNC_APPEND, pick_coord(span), pick_coord(span));
            end
            episode++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/pip_pkg.sv
hw/rtl/pip_ram.sv
hw/rtl/point_in_polygon_test.sv
verif/polygon_location_checker.sv
verif/point_in_polygon_test_tb.sv
